FILE: sv/adup_pkg.sv
// Shared constants and types for the DMX universe packer.
// No dependencies; imported by the packer top level and its checker.
`timescale 1ns / 1ps

package adup_pkg;

    localparam int SLOTS_PER_UNIVERSE       = 512;
    localparam int MAX_CHANNELS_PER_FIXTURE = 32;
    localparam int MIN_CHANNELS_PER_FIXTURE = 3;

    localparam int UNIV_W    = 15;
    localparam int SLOT_W    = 9;
    localparam int BYTE_W    = 8;
    localparam int SEQ_W     = 8;
    localparam int LEN_W     = 10;
    localparam int CPF_W     = 6;
    localparam int IDX_W     = 10;
    localparam int GAP_W     = 5;
    localparam int CFG_DATA_W = 15;

    localparam logic [SEQ_W-1:0] SEQ_FIRST = 8'd1;
    localparam logic [SEQ_W-1:0] SEQ_LAST  = 8'd255;

    typedef enum logic [1:0] {
        CFG_BASE_UNIVERSE        = 2'd0,
        CFG_CHANNELS_PER_FIXTURE = 2'd1,
        CFG_NO_SPLIT             = 2'd2
    } t_cfg_index;

endpackage

FILE: sv/artnet_dmx_universe_packer_top.sv
// DMX universe packer: places colour bytes into DMX slots, emits gap slots
// and packet close info. Depends on adup_pkg.
`timescale 1ns / 1ps

// A colour byte passes the input register and then the result register, from
// which it transfers. Throughput: one input byte per cycle when the fixture has
// 3 channels and the receiver does not stall; a fixture-closing byte holds the
// input while its gap slots (below slot 512) go out one per cycle unless stalled.
// Synchronous active-low reset clears all control state and loads register
// defaults: base_universe 1, channels_per_fixture 3, no_split 0.
module artnet_dmx_universe_packer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  adup_pkg::t_cfg_index                i_cfg_index,
    input  logic [adup_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [adup_pkg::BYTE_W-1:0]         i_color_byte,
    input  logic                                i_frame_last,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [adup_pkg::UNIV_W-1:0]         o_universe,
    output logic [adup_pkg::SLOT_W-1:0]         o_slot,
    output logic [adup_pkg::BYTE_W-1:0]         o_slot_value,
    output logic [adup_pkg::SEQ_W-1:0]          o_sequence_res,
    output logic                                o_packet_end,
    output logic [adup_pkg::LEN_W-1:0]          o_packet_length,
    output logic                                o_run_last
);
    import adup_pkg::*;

    localparam logic [IDX_W:0]   SLOTS_X = (IDX_W+1)'(SLOTS_PER_UNIVERSE);
    localparam logic [IDX_W-1:0] SLOTS_I = IDX_W'(SLOTS_PER_UNIVERSE);
    localparam logic [CPF_W-1:0] CPF_MIN = CPF_W'(MIN_CHANNELS_PER_FIXTURE);
    localparam logic [CPF_W-1:0] CPF_MAX = CPF_W'(MAX_CHANNELS_PER_FIXTURE);

    // configuration
    logic [UNIV_W-1:0] r_base_universe;
    logic [CPF_W-1:0]  r_cpf;
    logic              r_no_split;

    // packer state
    logic [IDX_W-1:0]  r_slot_index;
    logic [UNIV_W-1:0] r_cur_universe;
    logic [SEQ_W-1:0]  r_frame_seq;
    logic [1:0]        r_phase;
    logic              r_frame_open;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // pending gap writes of the byte now in the result register
    logic [GAP_W-1:0]  r_gap_left;
    logic [SLOT_W-1:0] r_gap_slot;
    logic              r_pend_close;
    logic [LEN_W-1:0]  r_pend_len;

    // result register
    logic              r_out_valid;
    logic [UNIV_W-1:0] r_out_universe;
    logic [SLOT_W-1:0] r_out_slot;
    logic [BYTE_W-1:0] r_out_value;
    logic [SEQ_W-1:0]  r_out_seq;
    logic              r_out_end;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_run_last;

    logic              out_free;
    logic              gaps_busy;
    logic              in_consume;
    logic              in_take;

    logic [CPF_W-1:0]  cpf_c;
    logic [UNIV_W-1:0] univ_use;
    logic              boundary;
    logic [IDX_W-1:0]  slot_p1;
    logic [IDX_W-1:0]  n_slot_raw;
    logic [IDX_W-1:0]  slot_clip;
    logic [IDX_W-1:0]  gap_cnt_w;
    logic [GAP_W-1:0]  gap_cnt;
    logic              close;
    logic [IDX_W:0]    len_raw;
    logic [LEN_W-1:0]  len_c;

    assign gaps_busy  = (r_gap_left != '0);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_consume = r_in_valid && out_free && !gaps_busy;
    assign o_in_stall = r_in_valid && !(out_free && !gaps_busy);
    assign in_take    = i_in_valid && !o_in_stall;

    // per-byte slot arithmetic, all decided when the byte leaves the input register
    always_comb begin
        if (r_cpf < CPF_MIN) begin
            cpf_c = CPF_MIN;
        end else if (r_cpf > CPF_MAX) begin
            cpf_c = CPF_MAX;
        end else begin
            cpf_c = r_cpf;
        end
        univ_use   = r_frame_open ? r_cur_universe : r_base_universe;
        boundary   = (r_phase >= 2'd2);
        slot_p1    = r_slot_index + IDX_W'(1);
        n_slot_raw = slot_p1 + (boundary ? IDX_W'(cpf_c - CPF_MIN) : '0);
        slot_clip  = (n_slot_raw > SLOTS_I) ? SLOTS_I : n_slot_raw;
        gap_cnt_w  = boundary ? (slot_clip - slot_p1) : '0;
        gap_cnt    = gap_cnt_w[GAP_W-1:0];
        close      = r_in_last || (n_slot_raw >= SLOTS_I) ||
                     (r_no_split && boundary &&
                      ({1'b0, n_slot_raw} + (IDX_W+1)'(cpf_c) > SLOTS_X));
        len_raw    = {1'b0, n_slot_raw} + (IDX_W+1)'(n_slot_raw[0]);
        len_c      = (len_raw > SLOTS_X) ? LEN_W'(SLOTS_PER_UNIVERSE) : len_raw[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_universe <= UNIV_W'(1);
            r_cpf           <= CPF_MIN;
            r_no_split      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_UNIVERSE:        r_base_universe <= i_cfg_wdata[UNIV_W-1:0];
                CFG_CHANNELS_PER_FIXTURE: r_cpf           <= i_cfg_wdata[CPF_W-1:0];
                CFG_NO_SPLIT:             r_no_split      <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_index   <= '0;
            r_cur_universe <= UNIV_W'(1);
            r_frame_seq    <= SEQ_FIRST;
            r_phase        <= '0;
            r_frame_open   <= 1'b0;
        end else if (in_consume) begin
            r_slot_index   <= close ? '0 : n_slot_raw;
            r_cur_universe <= close ? (univ_use + UNIV_W'(1)) : univ_use;
            r_frame_open   <= !r_in_last;
            r_phase        <= (r_in_last || boundary) ? 2'd0 : (r_phase + 2'd1);
            if (r_in_last) begin
                r_frame_seq <= (r_frame_seq >= SEQ_LAST) ? SEQ_FIRST
                                                         : (r_frame_seq + SEQ_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (in_consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_color_byte;
            r_in_last <= i_frame_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_gap_left  <= '0;
        end else if (out_free) begin
            if (gaps_busy) begin
                r_out_valid <= 1'b1;
                r_gap_left  <= r_gap_left - GAP_W'(1);
            end else if (r_in_valid) begin
                r_out_valid <= 1'b1;
                r_gap_left  <= gap_cnt;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; universe and sequence hold across a byte's gap writes
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (gaps_busy) begin
                r_out_slot     <= r_gap_slot;
                r_out_value    <= '0;
                r_out_end      <= r_pend_close && (r_gap_left == GAP_W'(1));
                r_out_len      <= (r_gap_left == GAP_W'(1)) ? r_pend_len : '0;
                r_out_run_last <= (r_gap_left == GAP_W'(1));
                r_gap_slot     <= r_gap_slot + SLOT_W'(1);
            end else if (r_in_valid) begin
                r_out_universe <= univ_use;
                r_out_seq      <= r_frame_seq;
                r_out_slot     <= r_slot_index[SLOT_W-1:0];
                r_out_value    <= r_in_byte;
                r_out_end      <= close && (gap_cnt == '0);
                r_out_len      <= (close && (gap_cnt == '0)) ? len_c : '0;
                r_out_run_last <= (gap_cnt == '0);
                r_gap_slot     <= slot_p1[SLOT_W-1:0];
                r_pend_close   <= close;
                r_pend_len     <= close ? len_c : '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_universe      = r_out_universe;
    assign o_slot          = r_out_slot;
    assign o_slot_value    = r_out_value;
    assign o_sequence_res  = r_out_seq;
    assign o_packet_end    = r_out_end;
    assign o_packet_length = r_out_len;
    assign o_run_last      = r_out_run_last;

endmodule

FILE: sv/adup_checker.sv
// Port-level checks for the DMX universe packer, bound to its top level.
// Depends on adup_pkg and artnet_dmx_universe_packer_top.
`timescale 1ns / 1ps

module adup_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [adup_pkg::SLOT_W-1:0]     o_slot,
    input logic [adup_pkg::SEQ_W-1:0]      o_sequence_res,
    input logic                            o_packet_end,
    input logic [adup_pkg::LEN_W-1:0]      o_packet_length,
    input logic                            o_run_last
);
    import adup_pkg::*;

    // a stalled result transfer keeps its slot
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_slot))
        else $error("result changed while stalled");

    // packet close always lands on the last write of its byte
    a_end_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_end |-> o_run_last)
        else $error("packet end not on last write of byte");

    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_packet_end |-> o_packet_length == '0)
        else $error("length reported outside packet end");

    a_len_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_end |->
            !o_packet_length[0] && o_packet_length <= LEN_W'(SLOTS_PER_UNIVERSE)
            && o_packet_length > {1'b0, o_slot})
        else $error("bad packet length");

    a_seq_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_sequence_res != '0)
        else $error("sequence number zero");

endmodule

bind artnet_dmx_universe_packer_top adup_checker u_adup_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_slot          (o_slot),
    .o_sequence_res  (o_sequence_res),
    .o_packet_end    (o_packet_end),
    .o_packet_length (o_packet_length),
    .o_run_last      (o_run_last)
);

FILE: bench/tb_top.sv
// Self-checking bench for the DMX universe packer: a slot-write predictor and
// scoreboard class, plus tasks that drive bytes and register writes.
// Depends on adup_pkg and artnet_dmx_universe_packer_top.
`timescale 1ns / 1ps

module tb_top;
    import adup_pkg::*;

    typedef struct packed {
        logic [UNIV_W-1:0] universe;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] value;
        logic [SEQ_W-1:0]  seq;
        logic              packet_end;
        logic [LEN_W-1:0]  length;
        logic              run_last;
    } t_slot_write;

    class dmx_slot_scoreboard;
        logic [UNIV_W-1:0] base_univ;
        logic [CPF_W-1:0]  fixture_cpf;
        logic              keep_whole;

        logic [IDX_W-1:0]  slot_pos;
        logic [UNIV_W-1:0] univ;
        logic [SEQ_W-1:0]  seq;
        logic [1:0]        phase;
        logic              frame_open;

        t_slot_write       pending_writes[$];
        int                error_count;

        function new();
            base_univ   = 15'd1;
            fixture_cpf = 6'd3;
            keep_whole  = 1'b0;
            slot_pos    = '0;
            univ        = base_univ;
            seq         = SEQ_FIRST;
            phase       = '0;
            frame_open  = 1'b0;
            error_count = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_BASE_UNIVERSE:        base_univ = val[UNIV_W-1:0];
                CFG_CHANNELS_PER_FIXTURE: fixture_cpf = val[CPF_W-1:0];
                CFG_NO_SPLIT:             keep_whole = val[0];
                default: ;
            endcase
        endfunction

        function t_slot_write make_write(logic [IDX_W-1:0] pos, logic [BYTE_W-1:0] val);
            t_slot_write w;
            w            = '0;
            w.universe   = univ;
            w.slot       = pos[SLOT_W-1:0];
            w.value      = val;
            w.seq        = seq;
            return w;
        endfunction

        // Expected slot writes for one accepted color byte.
        function void note_byte(logic [BYTE_W-1:0] color, logic last);
            t_slot_write step_q[$];
            int          width;
            int          len;
            int          tail;
            bit          boundary;
            bit          close;
            width    = int'(fixture_cpf);
            boundary = 0;
            if (width < MIN_CHANNELS_PER_FIXTURE) width = MIN_CHANNELS_PER_FIXTURE;
            if (width > MAX_CHANNELS_PER_FIXTURE) width = MAX_CHANNELS_PER_FIXTURE;
            if (!frame_open) begin
                univ       = base_univ;
                frame_open = 1'b1;
            end
            step_q.push_back(make_write(slot_pos, color));
            slot_pos++;
            if (phase >= 2) begin
                boundary = 1;
                phase    = '0;
                // gap slots past slot 511 are not written but still count toward the length
                for (int g = 0; g < width - 3; g++) begin
                    if (int'(slot_pos) < SLOTS_PER_UNIVERSE)
                        step_q.push_back(make_write(slot_pos, '0));
                    slot_pos++;
                end
            end else begin
                phase++;
            end
            close = last || int'(slot_pos) >= SLOTS_PER_UNIVERSE ||
                    (keep_whole && boundary && int'(slot_pos) + width > SLOTS_PER_UNIVERSE);
            tail = step_q.size() - 1;
            if (close) begin
                len = int'(slot_pos) + int'(slot_pos[0]);
                if (len > SLOTS_PER_UNIVERSE) len = SLOTS_PER_UNIVERSE;
                step_q[tail].packet_end = 1'b1;
                step_q[tail].length     = len[LEN_W-1:0];
                univ     = univ + 1'b1;
                slot_pos = '0;
            end
            step_q[tail].run_last = 1'b1;
            if (last) begin
                phase      = '0;
                frame_open = 1'b0;
                seq        = (seq >= SEQ_LAST) ? SEQ_FIRST : seq + 1'b1;
            end
            foreach (step_q[i]) pending_writes.push_back(step_q[i]);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            error_count++;
        endtask

        task check_write(t_slot_write got);
            t_slot_write want;
            if (pending_writes.size() == 0) begin
                report($sformatf("slot write u%0d s%0d with none pending",
                                 got.universe, got.slot));
                return;
            end
            want = pending_writes.pop_front();
            if (got.universe !== want.universe)
                report($sformatf("universe %0d, want %0d", got.universe, want.universe));
            if (got.slot !== want.slot)
                report($sformatf("slot %0d, want %0d", got.slot, want.slot));
            if (got.value !== want.value)
                report($sformatf("slot %0d value %0h, want %0h",
                                 want.slot, got.value, want.value));
            if (got.seq !== want.seq)
                report($sformatf("sequence %0d, want %0d", got.seq, want.seq));
            if (got.packet_end !== want.packet_end)
                report($sformatf("slot %0d packet_end %0b, want %0b",
                                 want.slot, got.packet_end, want.packet_end));
            if (got.length !== want.length)
                report($sformatf("slot %0d length %0d, want %0d",
                                 want.slot, got.length, want.length));
            if (got.run_last !== want.run_last)
                report($sformatf("slot %0d run_last %0b, want %0b",
                                 want.slot, got.run_last, want.run_last));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 900_000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    t_cfg_index             i_cfg_index = CFG_BASE_UNIVERSE;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [BYTE_W-1:0]      i_color_byte = '0;
    logic                   i_frame_last = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [UNIV_W-1:0]      o_universe;
    logic [SLOT_W-1:0]      o_slot;
    logic [BYTE_W-1:0]      o_slot_value;
    logic [SEQ_W-1:0]       o_sequence_res;
    logic                   o_packet_end;
    logic [LEN_W-1:0]       o_packet_length;
    logic                   o_run_last;

    dmx_slot_scoreboard sb = new();
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int frames_sent;

    artnet_dmx_universe_packer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_color_byte    (i_color_byte),
        .i_frame_last    (i_frame_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_universe      (o_universe),
        .o_slot          (o_slot),
        .o_slot_value    (o_slot_value),
        .o_sequence_res  (o_sequence_res),
        .o_packet_end    (o_packet_end),
        .o_packet_length (o_packet_length),
        .o_run_last      (o_run_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: long hold-off when requested, random stalls otherwise.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else begin
            i_out_stall = ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // Input transfers are noted before output transfers of the same edge.
    always @(posedge i_clk) begin
        t_slot_write got;
        cycle_count++;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_byte(i_color_byte, i_frame_last);
            if (o_out_valid && !i_out_stall) begin
                got = '{o_universe, o_slot, o_slot_value, o_sequence_res,
                        o_packet_end, o_packet_length, o_run_last};
                sb.check_write(got);
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task send_byte(logic [BYTE_W-1:0] color, logic last);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid   = 1'b0;
            i_color_byte = BYTE_W'($urandom);
            i_frame_last = 1'($urandom);
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_color_byte = color;
        i_frame_last = last;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        if (last) frames_sent++;
    endtask

    task wait_idle();
        i_in_valid = 1'b0;
        while (sb.pending_writes.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task write_reg(t_cfg_index idx, int unsigned val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val[CFG_DATA_W-1:0];
        sb.write_reg(idx, val[CFG_DATA_W-1:0]);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Frames of random content; the first frame of a phase is a long one.
    // A frame cut off at the phase end stays open into the next phase.
    task send_frames(int items, int long_lo, int long_hi, int short_hi, int min_frames);
        int sent;
        int left;
        bit first;
        sent  = 0;
        left  = 0;
        first = 1;
        while (sent < items || frames_sent < min_frames) begin
            if (left == 0) begin
                if (first || $urandom_range(1, 0))
                    left = $urandom_range(long_hi, long_lo);
                else
                    left = $urandom_range(short_hi, 1);
                first = 0;
            end
            send_byte(BYTE_W'($urandom), left == 1);
            left--;
            sent++;
        end
    endtask

    task run_phase(int unsigned base, int unsigned cpf, int unsigned whole,
                   int idle_pct, int stall_pct, int hold, int items,
                   int long_lo, int long_hi, int short_hi, int min_frames);
        wait_idle();
        write_reg(CFG_BASE_UNIVERSE, base);
        write_reg(CFG_CHANNELS_PER_FIXTURE, cpf);
        write_reg(CFG_NO_SPLIT, whole);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_left      = hold;
        send_frames(items, long_lo, long_hi, short_hi, min_frames);
    endtask

    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        frames_sent    = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // register defaults straight after reset
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        // top universe, fixture width below range, odd length padded
        wait_idle();
        write_reg(CFG_BASE_UNIVERSE, 32767);
        write_reg(CFG_CHANNELS_PER_FIXTURE, 0);
        write_reg(CFG_NO_SPLIT, 1);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h01, 1'b1);

        // widest fixture via an above-range width
        wait_idle();
        write_reg(CFG_CHANNELS_PER_FIXTURE, 63);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h01, 1'b1);

        wait_idle();
        write_reg(CFG_CHANNELS_PER_FIXTURE, 33);
        send_byte(8'hC3, 1'b1);

        // base change mid-frame only applies from the next frame
        wait_idle();
        write_reg(CFG_CHANNELS_PER_FIXTURE, 1);
        write_reg(CFG_BASE_UNIVERSE, 0);
        write_reg(CFG_NO_SPLIT, 0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h99, 1'b0);
        wait_idle();
        write_reg(CFG_BASE_UNIVERSE, 500);
        send_byte(8'h66, 1'b1);
        send_byte(8'h11, 1'b1);

        wait_idle();
        write_reg(CFG_CHANNELS_PER_FIXTURE, 32);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b1);

        // full universe at the top number, universe wraps to zero
        run_phase(32767, 32, 0, 0, 0, 0, 60, 48, 60, 3, 0);
        // gap slots run past slot 511, length capped
        run_phase(0, 31, 0, 73, 0, 0, 60, 51, 58, 3, 0);
        // early close to keep fixtures whole; long receiver hold-off
        run_phase($urandom_range(32767, 0), 31, 1, 0, 73, 400, 60, 48, 60, 3, 0);
        // one-byte frames until the sequence number wraps
        run_phase($urandom_range(32767, 0), $urandom_range(63, 0), $urandom_range(1, 0),
                  9, 9, 0, 40, 1, 1, 1, 256);

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (sb.error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

FILE: sim.f
sv/adup_pkg.sv
sv/artnet_dmx_universe_packer_top.sv
sv/adup_checker.sv
bench/tb_top.sv
